>>> design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the infix to postfix converter
// Request and result payloads, stack cell opcodes, controller states,
// operator characters and the precedence table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  // Operator characters
  localparam logic [7:0] SYM_CARET  = 8'h5E;
  localparam logic [7:0] SYM_STAR   = 8'h2A;
  localparam logic [7:0] SYM_SLASH  = 8'h2F;
  localparam logic [7:0] SYM_PLUS   = 8'h2B;
  localparam logic [7:0] SYM_MINUS  = 8'h2D;
  localparam logic [7:0] SYM_LPAREN = 8'h28;
  localparam logic [7:0] SYM_RPAREN = 8'h29;
  localparam logic [7:0] SYM_NUL    = 8'h00;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       last_in_run;
    logic       expression_done;
    logic       error;
  } result_t;

  // Per-cycle command to every cell of the stack chain
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAIN,
    ST_FLUSH
  } ctrl_state_t;

  // Precedence offset by one: ^ 4, * / 3, + - 2, ( 1, anything else 0
  function automatic logic [2:0] prec_of(input logic [7:0] c);
    logic [2:0] p;
    case (c)
      SYM_CARET:            p = 3'd4;
      SYM_STAR, SYM_SLASH:  p = 3'd3;
      SYM_PLUS, SYM_MINUS:  p = 3'd2;
      SYM_LPAREN:           p = 3'd1;
      default:              p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

>>> design/itp_cell.sv
// ----------------------------------------------------------------------------
// itp_cell: one entry of the shifting operator stack
// Holds one character; on a push it takes the entry above it (toward the top),
// on a pop it takes the entry below it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_cell import itp_pkg::*; (
  input  logic       clk,
  input  stk_op_t    op,
  input  logic [7:0] push_in,
  input  logic [7:0] pop_in,
  output logic [7:0] entry
);

  // Shift with the neighbors or hold
  always_ff @(posedge clk) begin
    case (op)
      STK_PUSH: entry <= push_in;
      STK_POP:  entry <= pop_in;
      default:  entry <= entry;
    endcase
  end

endmodule

>>> design/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack: operator stack built as a chain of shifting cells
// Cell 0 is the top of stack; all cells shift together on push or pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_stack import itp_pkg::*; (
  input  logic       clk,
  input  stk_op_t    op,
  input  logic [7:0] push_sym,
  output logic [7:0] top
);

  logic [7:0] entry [STACK_DEPTH];

  // Build the chain; the new symbol enters at the top, zero fills the bottom
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] push_in;
    logic [7:0] pop_in;

    if (i == 0) begin : g_top
      assign push_in = push_sym;
    end else begin : g_mid
      assign push_in = entry[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign pop_in = SYM_NUL;
    end else begin : g_up
      assign pop_in = entry[i+1];
    end

    itp_cell u_cell (
      .clk     (clk),
      .op      (op),
      .push_in (push_in),
      .pop_in  (pop_in),
      .entry   (entry[i])
    );
  end

  assign top = entry[0];

endmodule

>>> design/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: shunting-yard infix to postfix converter
// Takes one character per request and streams postfix characters out.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request steps through ST_IDLE, ST_MAIN
// and ST_FLUSH, plus a step per operator popped and emitted from the stack
// (pops before a push, pops up to a ')' and the end-of-expression flush), as
// the cell chain pops one entry per cycle when results can be emitted; the
// matching '(' is dropped with no extra step. A full result register held by
// stall makes the controller wait. Results of a request are buffered one deep
// so the last one can be marked; the stack holds STACK_DEPTH shifting cells.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit import itp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ctrl_state_t         state, state_next;
  logic [7:0]          sym;
  logic                eoe;
  logic [COUNT_W-1:0]  count, count_next;
  logic                hold_valid;
  logic [7:0]          hold_sym;
  logic                hold_err;

  stk_op_t             stk_op;
  logic [7:0]          top;
  logic                out_free;
  logic                can_emit;
  logic                full;
  logic                produce;
  logic [7:0]          prod_sym;
  logic                prod_err;
  logic                fin_load;
  logic                out_load;
  result_t             out_data;
  logic                accept;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign can_emit   = !hold_valid || out_free;
  assign full       = (count == COUNT_W'(STACK_DEPTH));

  itp_stack u_stack (
    .clk      (clk),
    .op       (stk_op),
    .push_sym (sym),
    .top      (top)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (produce) begin
        hold_valid <= 1'b1;
      end else if (fin_load) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Latch the request and the pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      sym <= item.symbol;
      eoe <= item.end_of_expression;
    end
    if (produce) begin
      hold_sym <= prod_sym;
      hold_err <= prod_err;
    end
  end

  // Next state, stack commands and produced results
  always_comb begin
    state_next = state;
    count_next = count;
    stk_op     = STK_HOLD;
    produce    = 1'b0;
    prod_sym   = SYM_NUL;
    prod_err   = 1'b0;
    fin_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_MAIN;
        end
      end
      ST_MAIN: begin
        case (sym)
          SYM_LPAREN: begin
            if (full) begin
              if (can_emit) begin
                produce    = 1'b1;
                prod_err   = 1'b1;
                count_next = '0;
                state_next = ST_FLUSH;
              end
            end else begin
              stk_op     = STK_PUSH;
              count_next = count + 1'b1;
              state_next = ST_FLUSH;
            end
          end
          SYM_RPAREN: begin
            if (count == '0) begin
              if (can_emit) begin
                produce    = 1'b1;
                prod_err   = 1'b1;
                state_next = ST_FLUSH;
              end
            end else if (top == SYM_LPAREN) begin
              stk_op     = STK_POP;
              count_next = count - 1'b1;
              state_next = ST_FLUSH;
            end else if (can_emit) begin
              stk_op     = STK_POP;
              count_next = count - 1'b1;
              produce    = 1'b1;
              prod_sym   = top;
            end
          end
          SYM_CARET, SYM_STAR, SYM_SLASH, SYM_PLUS, SYM_MINUS: begin
            if ((count != '0) && (prec_of(top) >= prec_of(sym))) begin
              if (can_emit) begin
                stk_op     = STK_POP;
                count_next = count - 1'b1;
                produce    = 1'b1;
                prod_sym   = top;
              end
            end else if (full) begin
              if (can_emit) begin
                produce    = 1'b1;
                prod_err   = 1'b1;
                count_next = '0;
                state_next = ST_FLUSH;
              end
            end else begin
              stk_op     = STK_PUSH;
              count_next = count + 1'b1;
              state_next = ST_FLUSH;
            end
          end
          default: begin
            if (can_emit) begin
              produce    = 1'b1;
              prod_sym   = sym;
              state_next = ST_FLUSH;
            end
          end
        endcase
      end
      ST_FLUSH: begin
        if (eoe && (count != '0)) begin
          if (can_emit) begin
            stk_op     = STK_POP;
            count_next = count - 1'b1;
            produce    = 1'b1;
            prod_sym   = top;
          end
        end else if (hold_valid || eoe) begin
          if (out_free) begin
            fin_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Pick what goes to the result register
  assign out_load = (produce && hold_valid) || fin_load;

  always_comb begin
    out_data = '{out_symbol: hold_sym, last_in_run: 1'b0, expression_done: 1'b0,
                 error: hold_err};
    if (fin_load) begin
      if (hold_valid) begin
        out_data = '{out_symbol: hold_sym, last_in_run: 1'b1, expression_done: eoe,
                     error: hold_err};
      end else begin
        out_data = '{out_symbol: SYM_NUL, last_in_run: 1'b1, expression_done: 1'b1,
                     error: 1'b0};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= out_data;
    end
  end

  // Stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // A new request finds no pending result of the previous one
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    accept |-> !hold_valid)
    else $error("request accepted with a pending result");

  // The end of the expression is always the last result of its request
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.expression_done) |-> result.last_in_run)
    else $error("expression done without last in run");

  // Error results carry no character
  a_err_nul: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.error) |-> (result.out_symbol == SYM_NUL))
    else $error("error result with a character");

endmodule
